// ===== design/dpnc_pkg.sv =====
// shared types, constants and keyword table for the digest parameter name classifier
package dpnc_pkg;

   localparam int unsigned OffsetWidthDefault = 16;
   localparam int unsigned NumKw = 10;
   localparam int unsigned KwMaxLen = 9;
   localparam int unsigned MinLen = 4;
   localparam int unsigned EqOffsetWidth = 16;

   localparam logic [7:0] CharEquals = 8'h3D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab = 8'h09;
   localparam logic [7:0] CharCr = 8'h0D;
   localparam logic [7:0] CharLf = 8'h0A;

   typedef logic [3:0] kind_type;

   localparam kind_type KindUsername = 4'd0;
   localparam kind_type KindRealm = 4'd1;
   localparam kind_type KindNonce = 4'd2;
   localparam kind_type KindUri = 4'd3;
   localparam kind_type KindResponse = 4'd4;
   localparam kind_type KindAlgorithm = 4'd5;
   localparam kind_type KindCnonce = 4'd6;
   localparam kind_type KindOpaque = 4'd7;
   localparam kind_type KindQop = 4'd8;
   localparam kind_type KindNc = 4'd9;
   localparam kind_type KindOther = 4'd10;

   typedef logic [KwMaxLen*8-1:0] kw_text_type;
   typedef logic [3:0] kw_len_type;

   // keyword text, right-justified: first character sits in the highest used byte
   localparam kw_text_type KwText [NumKw] = '{
      "username", "realm", "nonce", "uri", "response",
      "algorithm", "cnonce", "opaque", "qop", "nc"
   };
   localparam kw_len_type KwLen [NumKw] = '{
      4'd8, 4'd5, 4'd5, 4'd3, 4'd8, 4'd9, 4'd6, 4'd6, 4'd3, 4'd2
   };

   typedef enum logic [3:0] {
      PH_NAME   = 4'b0001,
      PH_BLANKS = 4'b0010,
      PH_OTHER  = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [NumKw-1:0] alive;
      kind_type         kind;
      phase_type        phase;
      logic             eq_seen;
   } match_state_type;

   localparam match_state_type MatchReset = '{
      alive:   {NumKw{1'b1}},
      kind:    KindOther,
      phase:   PH_NAME,
      eq_seen: 1'b0
   };

   // ascii upper to lower, nothing else folds
   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CharSpace) || (c == CharTab) || (c == CharCr) || (c == CharLf);
   endfunction

endpackage

// ===== design/dpnc_match.sv =====
// per-byte keyword match and scan phase update
module dpnc_match #(
   parameter int unsigned OFFSET_WIDTH = dpnc_pkg::OffsetWidthDefault
) (
   input  logic [7:0]                 char_in,
   input  logic [OFFSET_WIDTH-1:0]    pos,
   input  dpnc_pkg::match_state_type  state_cur,
   output dpnc_pkg::match_state_type  state_nxt,
   output logic                       eq_hit
);
   import dpnc_pkg::*;

   logic [7:0]       lc;
   logic [NumKw-1:0] alive_next;
   logic [NumKw-1:0] done_at;
   kind_type         hit_kind;
   logic             any_done;

   assign lc = fold_case(char_in);

   for (genvar k = 0; k < NumKw; k++) begin : g_kw
      localparam int unsigned Len = int'(KwLen[k]);
      logic             in_range;
      logic [7:0]       kw_c;
      logic [3:0]       sel;

      assign in_range = pos < OFFSET_WIDTH'(Len);
      assign sel = in_range ? 4'(Len - 1) - pos[3:0] : 4'd0;
      assign kw_c = KwText[k][sel*8 +: 8];
      assign alive_next[k] = state_cur.alive[k] && in_range && (kw_c == lc);
      assign done_at[k] = alive_next[k] && (pos == OFFSET_WIDTH'(Len - 1));
   end

   // at most one keyword can complete on a given byte
   always_comb begin
      hit_kind = KindOther;
      for (int k = 0; k < NumKw; k++) begin
         if (done_at[k]) begin
            hit_kind = kind_type'(k);
         end
      end
   end

   assign any_done = |done_at;

   always_comb begin
      state_nxt = state_cur;
      eq_hit = 1'b0;
      priority if (state_cur.phase != PH_DONE && char_in == CharEquals) begin
         state_nxt.eq_seen = 1'b1;
         eq_hit = 1'b1;
         if (state_cur.phase != PH_BLANKS) begin
            state_nxt.kind = KindOther;
         end
         state_nxt.phase = PH_DONE;
      end else if (state_cur.phase == PH_NAME) begin
         state_nxt.alive = alive_next;
         if (any_done) begin
            state_nxt.kind = hit_kind;
            state_nxt.phase = PH_BLANKS;
         end else if (alive_next == '0) begin
            state_nxt.phase = PH_OTHER;
         end
      end else if (state_cur.phase == PH_BLANKS) begin
         if (!is_blank(char_in)) begin
            state_nxt.kind = KindOther;
            state_nxt.phase = PH_OTHER;
         end
      end else begin
         state_nxt = state_cur;
      end
   end

endmodule

// ===== design/digest_param_name_classifier.sv =====
// top level: digest auth parameter name classifier, one byte per cycle
// the result of a string is registered into the result register on rsp_ once its last byte leaves the input register
// throughput: one byte per cycle; the input register and result register each hold one stage
// a result waiting on rsp_ready stalls the byte stream only when the next last byte needs it
// reset: synchronous, active high; clears the match state, byte count and both valid flags
module digest_param_name_classifier #(
   parameter int unsigned OFFSET_WIDTH = dpnc_pkg::OffsetWidthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_char_in,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dpnc_pkg::kind_type                 rsp_param_type,
   output logic                               rsp_eq_found,
   output logic [dpnc_pkg::EqOffsetWidth-1:0] rsp_eq_offset
);
   import dpnc_pkg::*;

   localparam logic [OFFSET_WIDTH-1:0] CountMax = '1;

   // input register
   logic                    in_valid_ff;
   logic [7:0]              in_char_ff;
   logic                    in_last_ff;

   // per-string scan state
   match_state_type         state_ff;
   match_state_type         state_in;
   match_state_type         state_nxt;
   logic [OFFSET_WIDTH-1:0] count_ff;
   logic [OFFSET_WIDTH-1:0] count_in;
   logic [OFFSET_WIDTH-1:0] eq_pos_ff;
   logic [OFFSET_WIDTH-1:0] eq_pos_in;
   logic                    eq_hit;

   // result register
   logic                    rsp_valid_ff;
   kind_type                rsp_type_ff;
   logic                    rsp_eq_ff;
   logic [EqOffsetWidth-1:0] rsp_off_ff;

   logic                    out_free;
   logic                    advance;
   logic                    consume;
   logic [OFFSET_WIDTH-1:0] count_inc;
   logic [OFFSET_WIDTH-1:0] pos_final;
   logic [OFFSET_WIDTH+EqOffsetWidth-1:0] pos_ext;
   kind_type                kind_final;

   dpnc_match #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_match (
      .char_in   (in_char_ff),
      .pos       (count_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .eq_hit    (eq_hit)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   // the held byte moves on unless it is a last byte with nowhere to put its result
   assign advance = !in_valid_ff || !in_last_ff || out_free;
   assign consume = in_valid_ff && advance;
   assign req_ready = advance;

   // byte count saturates at the top of the offset range
   assign count_inc = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
   assign pos_final = eq_hit ? count_ff : eq_pos_ff;

   // keyword only counts with an equals sign and at least the minimum length
   assign kind_final = (state_nxt.eq_seen && count_inc >= OFFSET_WIDTH'(MinLen))
                     ? state_nxt.kind : KindOther;

   // offset port keeps the low bits, zero-extended when the counter is narrower
   assign pos_ext = {{EqOffsetWidth{1'b0}}, pos_final};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      eq_pos_in = eq_pos_ff;
      if (consume) begin
         if (in_last_ff) begin
            // string done: back to the start state for the next one
            state_in = MatchReset;
            count_in = '0;
            eq_pos_in = '0;
         end else begin
            state_in = state_nxt;
            count_in = count_inc;
            eq_pos_in = pos_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MatchReset;
         count_ff <= '0;
         eq_pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         eq_pos_ff <= eq_pos_in;
      end
   end

   // result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (consume && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && in_last_ff) begin
         rsp_type_ff <= kind_final;
         rsp_eq_ff <= state_nxt.eq_seen;
         rsp_off_ff <= state_nxt.eq_seen ? pos_ext[EqOffsetWidth-1:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_param_type = rsp_type_ff;
   assign rsp_eq_found = rsp_eq_ff;
   assign rsp_eq_offset = rsp_off_ff;

`ifndef NO_ASSERTIONS
   // no equals sign means type other and offset zero
   a_no_eq_other : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_eq_found |-> rsp_param_type == KindOther && rsp_eq_offset == '0)
      else $error("result without equals sign carries a keyword or offset");

   // waiting for trailing blanks only after a keyword completed
   a_blanks_kind : assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_BLANKS |-> state_ff.kind != KindOther)
      else $error("blank phase without a matched keyword");

   // a finished string leaves the scan state at its start
   a_restart : assert property (@(posedge clock) disable iff (reset)
      consume && in_last_ff |=> count_ff == '0 && state_ff == MatchReset)
      else $error("scan state not restarted after last byte");

   // input stalls only behind a held result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && in_valid_ff && in_last_ff)
      else $error("input stalled without a blocked result");
`endif

endmodule
